>>> rtl/thp_pkg.sv
`timescale 1ns / 1ps
// thp_pkg: shared types, constants and code-class functions of the tls header parser
// depends on: nothing
package thp_pkg;

    // field sizes and limits
    localparam logic [5:0] RANDOM_BYTES   = 6'd32;
    localparam logic [7:0] MAX_SESSION_ID = 8'd32;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

    // record content types and handshake types
    localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0] HS_SERVER_HELLO = 8'h02;
    localparam logic [7:0] HS_CERTIFICATE  = 8'h0B;

    // result kinds
    typedef enum logic [3:0] {
        K_TYPE      = 4'd0,
        K_REC_VER   = 4'd1,
        K_REC_LEN   = 4'd2,
        K_HS_TYPE   = 4'd3,
        K_HS_LEN    = 4'd4,
        K_HELLO_VER = 4'd5,
        K_RANDOM    = 4'd6,
        K_SID_LEN   = 4'd7,
        K_SID_BYTE  = 4'd8,
        K_SUITE_LEN = 4'd9,
        K_SUITE     = 4'd10,
        K_CERT_LEN  = 4'd11,
        K_PAYLOAD   = 4'd12,
        K_TRUNC     = 4'd13
    } t_kind;

    // word passed from the parser to the classifier
    typedef struct packed {
        t_kind       kind;
        logic [23:0] value;
        logic        done;
    } t_entry;

    // content type class: 0x14..0x17 map to 0..3, anything else 4
    function automatic logic [3:0] type_class(input logic [7:0] t);
        logic [7:0] d;
        d = t - 8'h14;
        if (t inside {[8'h14:8'h17]}) return {2'b00, d[1:0]};
        return 4'd4;
    endfunction

    // protocol version class
    function automatic logic [3:0] version_class(input logic [15:0] v);
        logic [7:0] minor_m1;
        minor_m1 = v[7:0] - 8'd1;
        if (v[15:8] != 8'h03) return 4'd4;
        if (v[7:0] inside {[8'd1:8'd3]}) return {2'b00, minor_m1[1:0]};
        return 4'd3;
    endfunction

    // handshake type class, 8 for unknown
    function automatic logic [3:0] hs_class(input logic [7:0] t);
        case (t)
            8'h01:   return 4'd0;
            8'h02:   return 4'd1;
            8'h0B:   return 4'd2;
            8'h04:   return 4'd3;
            8'h0C:   return 4'd4;
            8'h0E:   return 4'd5;
            8'h10:   return 4'd6;
            8'h14:   return 4'd7;
            default: return 4'd8;
        endcase
    endfunction

    // cipher suite class, 11 for unknown
    function automatic logic [3:0] suite_class(input logic [15:0] s);
        case (s)
            16'h000a: return 4'd0;
            16'h002f: return 4'd1;
            16'h0035: return 4'd2;
            16'h009c: return 4'd3;
            16'h009d: return 4'd4;
            16'hc013: return 4'd5;
            16'hc014: return 4'd6;
            16'hc02b: return 4'd7;
            16'hc02c: return 4'd8;
            16'hc02f: return 4'd9;
            16'hc030: return 4'd10;
            default:  return 4'd11;
        endcase
    endfunction

endpackage

>>> rtl/thp_ifs.sv
`timescale 1ns / 1ps
// thp_ifs: valid/ready channels for record bytes and parsed results
// depends on: nothing

// byte channel into the parser
interface thp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_record;

    modport source (output valid, rx_byte, end_of_record, input ready);
    modport sink   (input valid, rx_byte, end_of_record, output ready);
endinterface

// result channel out of the parser
interface thp_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_kind;
    logic [23:0] field_value;
    logic [3:0]  class_code;
    logic        record_done;

    modport source (output valid, field_kind, field_value, class_code, record_done,
                    input ready);
    modport sink   (input valid, field_kind, field_value, class_code, record_done,
                    output ready);
endinterface

>>> rtl/thp_front.sv
`timescale 1ns / 1ps
// thp_front: byte-level record parser, tracks the field phase and builds field words
// depends on: thp_pkg, thp_ifs
module thp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    thp_byte_if.sink        i_rx,
    input  logic            i_q_full,
    output logic            o_push,
    output thp_pkg::t_entry o_entry
);
    import thp_pkg::*;

    typedef enum logic [3:0] {
        PH_TYPE, PH_RVER, PH_RLEN, PH_HTYPE, PH_HLEN, PH_HVER, PH_RAND,
        PH_SIDLEN, PH_SIDB, PH_SUITELEN, PH_SUITE, PH_CERTLEN, PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_bif, n_bif;
    logic [23:0] r_acc, n_acc;
    logic        r_rec_hs, n_rec_hs;
    logic [7:0]  r_hs_type, n_hs_type;
    logic [15:0] r_remain, n_remain;

    logic        accept;
    logic [7:0]  b;
    logic        eor;
    logic [1:0]  need;
    logic        multi;
    logic [23:0] acc_new;
    logic [5:0]  bif_inc;
    logic [15:0] remain_dec;
    logic [15:0] suite_cnt;

    // bytes per field for the current phase
    always_comb begin
        case (r_phase)
            PH_RVER, PH_RLEN, PH_HVER, PH_SUITELEN, PH_SUITE: need = 2'd2;
            PH_HLEN, PH_CERTLEN:                             need = 2'd3;
            default:                                         need = 2'd1;
        endcase
    end

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign eor        = i_rx.end_of_record;
    assign multi      = (need != 2'd1);
    assign acc_new    = {r_acc[15:0], b};
    assign bif_inc    = r_bif + 6'd1;
    assign remain_dec = r_remain - 16'd1;
    assign suite_cnt  = {1'b0, acc_new[15:1]};

    // phase sequencing and word building
    always_comb begin
        n_phase   = r_phase;
        n_bif     = r_bif;
        n_acc     = r_acc;
        n_rec_hs  = r_rec_hs;
        n_hs_type = r_hs_type;
        n_remain  = r_remain;
        o_push    = 1'b0;
        o_entry.kind  = K_PAYLOAD;
        o_entry.value = {16'd0, b};
        o_entry.done  = eor;

        if (accept) begin
            if (multi && (bif_inc < {4'd0, need})) begin
                // field still gathering bytes
                n_acc = acc_new;
                n_bif = bif_inc;
                if (eor) begin
                    o_push        = 1'b1;
                    o_entry.kind  = K_TRUNC;
                    o_entry.value = acc_new;
                end
            end else begin
                o_push = 1'b1;
                if (multi) begin
                    o_entry.value = acc_new;
                    n_acc = 24'd0;
                    n_bif = 6'd0;
                end
                case (r_phase)
                    PH_TYPE: begin
                        o_entry.kind = K_TYPE;
                        n_rec_hs     = (b == REC_HANDSHAKE);
                        n_phase      = PH_RVER;
                    end
                    PH_RVER: begin
                        o_entry.kind = K_REC_VER;
                        n_phase      = PH_RLEN;
                    end
                    PH_RLEN: begin
                        o_entry.kind = K_REC_LEN;
                        n_phase      = r_rec_hs ? PH_HTYPE : PH_PAYLOAD;
                    end
                    PH_HTYPE: begin
                        if (hs_class(b) != 4'd8) begin
                            o_entry.kind = K_HS_TYPE;
                            n_hs_type    = b;
                            n_phase      = PH_HLEN;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_HLEN: begin
                        o_entry.kind = K_HS_LEN;
                        if (r_hs_type == HS_CLIENT_HELLO || r_hs_type == HS_SERVER_HELLO) begin
                            n_phase = PH_HVER;
                        end else if (r_hs_type == HS_CERTIFICATE) begin
                            n_phase = PH_CERTLEN;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_HVER: begin
                        o_entry.kind = K_HELLO_VER;
                        n_phase      = PH_RAND;
                    end
                    PH_RAND: begin
                        o_entry.kind = K_RANDOM;
                        n_bif        = bif_inc;
                        if (bif_inc >= RANDOM_BYTES) begin
                            n_bif   = 6'd0;
                            n_phase = PH_SIDLEN;
                        end
                    end
                    PH_SIDLEN: begin
                        o_entry.kind = K_SID_LEN;
                        if (b > MAX_SESSION_ID) begin
                            n_phase = PH_PAYLOAD;
                        end else if (b == 8'd0) begin
                            if (r_hs_type == HS_CLIENT_HELLO) begin
                                n_phase = PH_SUITELEN;
                            end else begin
                                n_phase  = PH_SUITE;
                                n_remain = 16'd1;
                            end
                        end else begin
                            n_remain = {8'd0, b};
                            n_phase  = PH_SIDB;
                        end
                    end
                    PH_SIDB: begin
                        o_entry.kind = K_SID_BYTE;
                        n_remain     = remain_dec;
                        if (remain_dec == 16'd0) begin
                            if (r_hs_type == HS_CLIENT_HELLO) begin
                                n_phase = PH_SUITELEN;
                            end else begin
                                n_phase  = PH_SUITE;
                                n_remain = 16'd1;
                            end
                        end
                    end
                    PH_SUITELEN: begin
                        o_entry.kind = K_SUITE_LEN;
                        n_remain     = suite_cnt;
                        n_phase      = (suite_cnt == 16'd0) ? PH_PAYLOAD : PH_SUITE;
                    end
                    PH_SUITE: begin
                        o_entry.kind = K_SUITE;
                        n_remain     = remain_dec;
                        if (remain_dec == 16'd0) n_phase = PH_PAYLOAD;
                    end
                    PH_CERTLEN: begin
                        o_entry.kind = K_CERT_LEN;
                        n_phase      = PH_PAYLOAD;
                    end
                    default: begin
                        o_entry.kind = K_PAYLOAD;
                        n_phase      = PH_PAYLOAD;
                    end
                endcase
            end

            // last byte of the record: back to the header
            if (eor) begin
                n_phase   = PH_TYPE;
                n_bif     = 6'd0;
                n_acc     = 24'd0;
                n_rec_hs  = 1'b0;
                n_hs_type = 8'd0;
                n_remain  = 16'd0;
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_bif     <= 6'd0;
            r_acc     <= 24'd0;
            r_rec_hs  <= 1'b0;
            r_hs_type <= 8'd0;
            r_remain  <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_bif     <= n_bif;
            r_acc     <= n_acc;
            r_rec_hs  <= n_rec_hs;
            r_hs_type <= n_hs_type;
            r_remain  <= n_remain;
        end
    end

endmodule

>>> rtl/thp_queue.sv
`timescale 1ns / 1ps
// thp_queue: short word queue between the parser and the classifier
// depends on: thp_pkg
module thp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  thp_pkg::t_entry i_entry,
    input  logic            i_pop,
    output thp_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);
    import thp_pkg::*;

    t_entry              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QPTR_W:0]     r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QUEUE_DEPTH[QPTR_W:0]);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_slot[r_rptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wptr] <= i_entry;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + 1'b1;
            if (do_pop)  r_rptr <= r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/thp_back.sv
`timescale 1ns / 1ps
// thp_back: maps field codes to class numbers and holds the result output register
// depends on: thp_pkg, thp_ifs
module thp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  thp_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    thp_res_if.source       o_res
);
    import thp_pkg::*;

    logic        r_valid;
    t_kind       r_kind;
    logic [23:0] r_value;
    logic [3:0]  r_class;
    logic        r_done;
    logic [3:0]  n_class;
    logic        take;

    // class number for the queued word
    always_comb begin
        case (i_entry.kind)
            K_TYPE:                 n_class = type_class(i_entry.value[7:0]);
            K_REC_VER, K_HELLO_VER: n_class = version_class(i_entry.value[15:0]);
            K_HS_TYPE:              n_class = hs_class(i_entry.value[7:0]);
            K_SID_LEN:              n_class = (i_entry.value[7:0] > MAX_SESSION_ID) ? 4'd1
                                                                                    : 4'd0;
            K_SUITE:                n_class = suite_class(i_entry.value[15:0]);
            default:                n_class = 4'd0;
        endcase
    end

    assign take  = !r_valid || o_res.ready;
    assign o_pop = take && !i_empty;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= i_entry.kind;
            r_value <= i_entry.value;
            r_class <= n_class;
            r_done  <= i_entry.done;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.field_kind  = r_kind;
    assign o_res.field_value = r_value;
    assign o_res.class_code  = r_class;
    assign o_res.record_done = r_done;

endmodule

>>> rtl/tls_handshake_header_parser.sv
`timescale 1ns / 1ps
// tls_handshake_header_parser: top level, parser front, word queue and classifier back
// depends on: thp_pkg, thp_ifs, thp_front, thp_queue, thp_back
//
//  port     dir  what moves             word content
//  i_rx     in   record bytes           rx_byte, end_of_record
//  o_res    out  parsed field results   field_kind, field_value, class_code, record_done
//
// one byte is accepted per clock unless the queue is full; a byte that completes a field
// gives a result that reaches o_res through the queue write at the accepting edge, then
// the output register
// the four-entry queue lets the parser keep taking bytes while o_res is stalled;
// i_rx.ready drops only once the queue is full
// i_rst_n is synchronous, active low, and returns the parser to the record header
module tls_handshake_header_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    thp_byte_if.sink   i_rx,
    thp_res_if.source  o_res
);
    import thp_pkg::*;

    t_entry front_entry;
    t_entry queue_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;

    // byte parser
    thp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (front_entry)
    );

    // word queue
    thp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // classifier and output register
    thp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (queue_entry),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
